FILE: rtl/core/rss_pkg.sv
package rss_pkg;

	typedef enum logic [3:0] {
		ENG_IDLE,
		ENG_DIV_MEAN,
		ENG_MUL_A,
		ENG_MUL_B,
		ENG_SUB_NUM,
		ENG_MUL_D,
		ENG_DIV_VAR,
		ENG_SQRT,
		ENG_DONE
	} eng_state_t;

	typedef struct packed {
		logic start;
		logic take;
	} eng_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} eng_sts_t;

	localparam int unsigned FRAC_BITS = 8;

endpackage

FILE: rtl/core/running_sample_statistics.sv
// Channel  Dir  Payload                                                 Handshake
// s        in   tdata: sample; tuser: cmd                               tvalid/tready
// m        out  tdata: count,last,min,max,mean,variance,std_dev;        tvalid/tready
//               tuser: full_res
// One shared add/subtract unit runs bit-serial multiplies, two restoring divisions and
// a square root in turn for each item; the engine ends early when count is 0 or 1.
// s_tready is low from acceptance until the engine is back to idle; a result waiting
// on m_tready holds the engine at its end but the output register takes it first.
// Reset clears statistics, engine and output valid.
module running_sample_statistics
	import rss_pkg::*;
#(
	parameter int unsigned SAMPLE_WIDTH = 16,
	parameter int unsigned COUNT_WIDTH  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // sample
	input  logic s_tuser,                               // cmd
	output logic m_tvalid,
	input  logic m_tready,
	// count, last_value, minimum, maximum, mean, variance, std_dev
	output logic [((COUNT_WIDTH+7*SAMPLE_WIDTH+22+7)/8)*8-1:0] m_tdata,
	output logic m_tuser                                // full_res
);

	localparam int unsigned SW   = SAMPLE_WIDTH;
	localparam int unsigned CW   = COUNT_WIDTH;
	localparam int unsigned SUMW = SW + CW;
	localparam int unsigned SQW  = 2 * SW + CW - 1;
	localparam int unsigned MW   = SW + FRAC_BITS;
	localparam int unsigned VW   = 2 * SW + 6;
	localparam int unsigned VIW  = 2 * SW + FRAC_BITS;
	localparam int unsigned ODW  = ((CW + 7 * SW + 22 + 7) / 8) * 8;
	localparam int unsigned OFS_VAR = CW + 3 * SW + MW;

	logic [CW-1:0]          cnt_q;
	logic signed [SW-1:0]   last_q, min_q, max_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0]         sq_q;
	logic                   full_q;
	logic                   start_q;

	logic                   s_acc;
	logic signed [SW-1:0]   x;
	logic [SW-1:0]          ax;
	logic [SUMW-1:0]        abs_sum;
	logic [MW-1:0]          mean_abs, mean_s;
	logic [VIW-1:0]         var_full;
	logic [VW-1:0]          var_out;
	logic [MW-1:0]          root;
	eng_ctl_t               ctl;
	eng_sts_t               sts;
	logic                   out_load;

	logic                   m_tvalid_q;
	logic [ODW-1:0]         m_tdata_q;
	logic                   m_tuser_q;

	assign x        = s_tdata[SW-1:0];
	assign ax       = x[SW-1] ? SW'(-x) : SW'(x);
	assign s_tready = sts.idle && !start_q;
	assign s_acc    = s_tvalid && s_tready;
	assign abs_sum  = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			last_q  <= '0;
			min_q   <= '0;
			max_q   <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			full_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= s_acc;
			if (s_acc) begin
				if (s_tuser) begin
					cnt_q  <= '0;
					last_q <= '0;
					min_q  <= '0;
					max_q  <= '0;
					sum_q  <= '0;
					sq_q   <= '0;
					full_q <= 1'b0;
				end else if (cnt_q == '1) begin
					full_q <= 1'b1;
				end else begin
					full_q <= 1'b0;
					cnt_q  <= cnt_q + CW'(1);
					last_q <= x;
					if (cnt_q == '0 || x < min_q)
						min_q <= x;
					if (cnt_q == '0 || x > max_q)
						max_q <= x;
					sum_q <= sum_q + SUMW'(x);
					sq_q  <= sq_q + SQW'({{SW{1'b0}}, ax} * {{SW{1'b0}}, ax});
				end
			end
		end
	end

	assign ctl.start = start_q;
	assign ctl.take  = out_load;

	rss_engine #(
		.SW(SW),
		.CW(CW)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.n        (cnt_q),
		.abs_sum  (abs_sum),
		.sumsq    (sq_q),
		.mean_abs (mean_abs),
		.var_full (var_full),
		.root     (root)
	);

	assign mean_s   = sum_q[SUMW-1] ? MW'(-mean_abs) : mean_abs;
	assign var_out  = (|var_full[VIW-1:VW]) ? '1 : var_full[VW-1:0];
	assign out_load = sts.done && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= ODW'({root, var_out, mean_s, max_q, min_q, last_q, cnt_q});
			m_tuser_q <= full_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_no_accept_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !s_tready)
		else $error("item accepted while engine starting");

	a_full_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[CW-1:0] == '1))
		else $error("full result below count bound");

	a_var_small_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[CW-1:0] == '0 || m_tdata[CW-1:0] == CW'(1)))
		|-> (m_tdata[OFS_VAR+VW-1:OFS_VAR] == '0))
		else $error("variance nonzero with fewer than two samples");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (min_q <= max_q))
		else $error("minimum above maximum");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");

endmodule

FILE: rtl/core/rss_engine.sv
module rss_engine
	import rss_pkg::*;
#(
	parameter int unsigned SW = 16,
	parameter int unsigned CW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  eng_ctl_t              ctl,
	output eng_sts_t              sts,
	input  logic [CW-1:0]         n,
	input  logic [SW+CW-1:0]      abs_sum,
	input  logic [2*SW+CW-2:0]    sumsq,
	output logic [SW+7:0]         mean_abs,
	output logic [2*SW+7:0]       var_full,
	output logic [SW+7:0]         root
);

	localparam int unsigned SUMW = SW + CW;
	localparam int unsigned UW   = 2 * SUMW;
	localparam int unsigned DW   = UW + FRAC_BITS;
	localparam int unsigned MW   = SW + FRAC_BITS;
	localparam int unsigned VIW  = 2 * SW + FRAC_BITS;
	localparam int unsigned SQN  = (VIW + FRAC_BITS) / 2;
	localparam int unsigned ITW  = $clog2(DW + 1);

	eng_state_t state_q, state_d;
	logic [ITW-1:0]  it_q;
	logic [UW-1:0]   acc_q, opb_q, num_q;
	logic [SUMW-1:0] mpl_q;
	logic [DW-1:0]   dvd_q;
	logic [MW-1:0]   mean_q, std_q;
	logic [VIW-1:0]  varf_q;

	logic [UW:0]     add_a, add_b;
	logic            add_sub;
	logic [UW+1:0]   add_s;
	logic            ge;
	logic [UW-1:0]   diff;
	logic            last;
	logic [UW-1:0]   mul_acc;
	logic [VIW-1:0]  q_var;
	logic [UW-1:0]   root_nx;

	assign add_s = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
		+ {{(UW+1){1'b0}}, add_sub};
	assign ge      = add_s[UW+1];
	assign diff    = add_s[UW-1:0];
	assign last    = (it_q == ITW'(1));
	assign mul_acc = mpl_q[0] ? diff : acc_q;
	assign q_var   = {dvd_q[VIW-2:0], ge};
	assign root_nx = {opb_q[UW-2:0], ge};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (ctl.start)
					state_d = (n == '0) ? ENG_DONE : ENG_DIV_MEAN;
			end
			ENG_DIV_MEAN: begin
				if (last)
					state_d = (n < CW'(2)) ? ENG_DONE : ENG_MUL_A;
			end
			ENG_MUL_A:   if (last) state_d = ENG_MUL_B;
			ENG_MUL_B:   if (last) state_d = ENG_SUB_NUM;
			ENG_SUB_NUM: state_d = ENG_MUL_D;
			ENG_MUL_D:   if (last) state_d = ENG_DIV_VAR;
			ENG_DIV_VAR: if (last) state_d = ENG_SQRT;
			ENG_SQRT:    if (last) state_d = ENG_DONE;
			ENG_DONE:    if (ctl.take) state_d = ENG_IDLE;
			default:     state_d = ENG_IDLE;
		endcase
	end

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		sts.idle = (state_q == ENG_IDLE);
		sts.done = (state_q == ENG_DONE);
		unique case (state_q)
			ENG_MUL_A, ENG_MUL_B, ENG_MUL_D: begin
				add_a = {1'b0, acc_q};
				add_b = {1'b0, opb_q};
			end
			ENG_SUB_NUM: begin
				add_a   = {1'b0, num_q};
				add_b   = {1'b0, acc_q};
				add_sub = 1'b1;
			end
			ENG_DIV_MEAN, ENG_DIV_VAR: begin
				add_a   = {acc_q, dvd_q[DW-1]};
				add_b   = {1'b0, opb_q};
				add_sub = 1'b1;
			end
			ENG_SQRT: begin
				add_a   = {acc_q[UW-2:0], dvd_q[DW-1:DW-2]};
				add_b   = {1'b0, opb_q[UW-3:0], 2'b01};
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			it_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ENG_IDLE)
				it_q <= ITW'(SUMW + FRAC_BITS);
			else if (last) begin
				unique case (state_q)
					ENG_DIV_MEAN: it_q <= ITW'(CW);
					ENG_MUL_A:    it_q <= ITW'(SUMW);
					ENG_MUL_B:    it_q <= ITW'(CW);
					ENG_MUL_D:    it_q <= ITW'(DW);
					ENG_DIV_VAR:  it_q <= ITW'(SQN);
					default:      it_q <= it_q;
				endcase
			end else if (state_q == ENG_SUB_NUM)
				it_q <= ITW'(CW);
			else if (state_q != ENG_DONE)
				it_q <= it_q - ITW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ENG_IDLE: begin
				if (ctl.start) begin
					acc_q  <= '0;
					opb_q  <= UW'(n);
					dvd_q  <= DW'({abs_sum, 8'b0}) << (DW - SUMW - FRAC_BITS);
					mean_q <= '0;
					varf_q <= '0;
					std_q  <= '0;
				end
			end
			ENG_DIV_MEAN, ENG_DIV_VAR: begin
				if (last && state_q == ENG_DIV_MEAN) begin
					mean_q <= {dvd_q[MW-2:0], ge};
					acc_q  <= '0;
					opb_q  <= UW'(sumsq);
					mpl_q  <= SUMW'(n);
					dvd_q  <= {dvd_q[DW-2:0], ge};
				end else if (last && state_q == ENG_DIV_VAR) begin
					varf_q <= q_var;
					acc_q  <= '0;
					opb_q  <= '0;
					dvd_q  <= DW'({q_var, 8'b0}) << (DW - VIW - FRAC_BITS);
				end else begin
					if (ge)
						acc_q <= diff;
					else
						acc_q <= add_a[UW-1:0];
					dvd_q <= {dvd_q[DW-2:0], ge};
				end
			end
			ENG_MUL_A, ENG_MUL_B, ENG_MUL_D: begin
				if (last && state_q == ENG_MUL_A) begin
					num_q <= mul_acc;
					acc_q <= '0;
					opb_q <= UW'(abs_sum);
					mpl_q <= abs_sum;
				end else if (last && state_q == ENG_MUL_D) begin
					opb_q <= mul_acc;
					acc_q <= '0;
					dvd_q <= {num_q, 8'b0};
				end else begin
					acc_q <= mul_acc;
					opb_q <= {opb_q[UW-2:0], 1'b0};
					mpl_q <= {1'b0, mpl_q[SUMW-1:1]};
				end
			end
			ENG_SUB_NUM: begin
				num_q <= ge ? diff : '0;
				acc_q <= '0;
				opb_q <= UW'(n);
				mpl_q <= SUMW'(n - CW'(1));
			end
			ENG_SQRT: begin
				if (ge)
					acc_q <= diff;
				else
					acc_q <= add_a[UW-1:0];
				opb_q <= root_nx;
				dvd_q <= {dvd_q[DW-3:0], 2'b00};
				if (last)
					std_q <= root_nx[MW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign mean_abs = mean_q;
	assign var_full = varf_q;
	assign root     = std_q;

endmodule

FILE: sim/rss_tb_pkg.sv
package rss_tb_pkg;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_CLEAR = 1'b1
	} stat_cmd_t;

endpackage

FILE: sim/rss_checker.sv
module rss_checker
	import rss_pkg::*;
	import rss_tb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [15:0]  s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [151:0] m_tdata,
	input  logic         m_tuser,
	output int           errors,
	output int           pending,
	output int           results_seen,
	output int           peak_count
);

	typedef struct {
		logic [15:0]        count;
		logic signed [15:0] last_value;
		logic signed [15:0] minimum;
		logic signed [15:0] maximum;
		logic [23:0]        mean;
		logic [37:0]        variance;
		logic [23:0]        std_dev;
		logic               full_res;
	} stats_t;

	localparam longint unsigned COUNT_MAX = 64'd65535;
	localparam longint unsigned VAR_MAX   = (64'd1 << 38) - 1;
	localparam longint unsigned STD_MAX   = (64'd1 << 24) - 1;

	stats_t expected_stats[$];

	longint unsigned    n_samples;
	logic signed [15:0] last_s, min_s, max_s;
	longint             sum_s;
	longint unsigned    sumsq_s;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic stats_t update_stats(stat_cmd_t cmd, logic signed [15:0] x);
		stats_t          st;
		longint          xl;
		longint unsigned ax, abs_sum, mean_u, var_u, std_u, a, b, d, num, q, r;
		logic            neg;
		xl     = x;
		st.full_res = 1'b0;
		if (cmd == CMD_CLEAR) begin
			n_samples = 0;
			last_s = 0;
			min_s = 0;
			max_s = 0;
			sum_s = 0;
			sumsq_s = 0;
		end else if (n_samples >= COUNT_MAX) begin
			st.full_res = 1'b1;
		end else begin
			ax = (xl < 0) ? -xl : xl;
			n_samples++;
			last_s = x;
			if (n_samples == 1) begin
				min_s = x;
				max_s = x;
			end else begin
				if (x > max_s) max_s = x;
				if (x < min_s) min_s = x;
			end
			sum_s   = sum_s + xl;
			sumsq_s = sumsq_s + ax * ax;
		end
		neg     = sum_s < 0;
		abs_sum = neg ? -sum_s : sum_s;
		mean_u  = 0;
		var_u   = 0;
		std_u   = 0;
		if (n_samples != 0) begin
			mean_u = (abs_sum << FRAC_BITS) / n_samples;
			if (neg) mean_u = -mean_u;
		end
		if (n_samples > 1) begin
			a     = n_samples * sumsq_s;
			b     = abs_sum * abs_sum;
			d     = n_samples * (n_samples - 1);
			num   = (a > b) ? a - b : 0;
			q     = num / d;
			r     = num % d;
			var_u = (q << FRAC_BITS) + ((r << FRAC_BITS) / d);
			std_u = floor_sqrt(var_u << FRAC_BITS);
		end
		if (var_u > VAR_MAX) var_u = VAR_MAX;
		if (std_u > STD_MAX) std_u = STD_MAX;
		st.count      = n_samples[15:0];
		st.last_value = last_s;
		st.minimum    = min_s;
		st.maximum    = max_s;
		st.mean       = mean_u[23:0];
		st.variance   = var_u[37:0];
		st.std_dev    = std_u[23:0];
		return st;
	endfunction

	task automatic report(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, longint unsigned got, longint unsigned exp_v);
		if (got != exp_v)
			report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp_v));
	endtask

	initial begin
		errors = 0;
		results_seen = 0;
		peak_count = 0;
		n_samples = 0;
		last_s = 0;
		min_s = 0;
		max_s = 0;
		sum_s = 0;
		sumsq_s = 0;
	end

	assign pending = expected_stats.size();

	always @(posedge clk) begin
		stats_t e;
		if (arst_n && s_tvalid && s_tready) begin
			e = update_stats(stat_cmd_t'(s_tuser), s_tdata);
			expected_stats.push_back(e);
			if (e.count > peak_count) peak_count = e.count;
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_stats.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				e = expected_stats.pop_front();
				check_field("count", m_tdata[15:0], e.count);
				check_field("last_value", m_tdata[31:16], e.last_value[15:0]);
				check_field("minimum", m_tdata[47:32], e.minimum[15:0]);
				check_field("maximum", m_tdata[63:48], e.maximum[15:0]);
				check_field("mean", m_tdata[87:64], e.mean);
				check_field("variance", m_tdata[125:88], e.variance);
				check_field("std_dev", m_tdata[149:126], e.std_dev);
				check_field("full_res", m_tuser, e.full_res);
			end
		end
	end

endmodule

FILE: sim/tb_running_sample_statistics.sv
module tb_running_sample_statistics;
	import rss_tb_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic         s_tuser = CMD_ADD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;
	logic         m_tuser;

	logic s_acc = 1'b0;
	int   errors, pending, results_seen, peak_count;
	int   items_sent = 0;
	int   clears_sent = 0;
	int   hold_cycles = 0;
	bit   no_gaps = 0;

	always #1 clk = ~clk;

	running_sample_statistics uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	rss_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending), .results_seen(results_seen),
		.peak_count(peak_count)
	);

	always @(posedge clk) begin
		s_acc <= s_tvalid && s_tready;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	// receiver: random stalls, plus an explicit long hold-off on request
	initial begin
		int gap;
		gap = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (no_gaps) begin
				m_tready <= 1'b1;
			end else if (gap > 0) begin
				m_tready <= 1'b0;
				gap--;
			end else begin
				m_tready <= 1'b1;
				gap = pick_gap();
			end
		end
	end

	task automatic send_item(stat_cmd_t cmd, logic [15:0] x);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= x;
		do @(negedge clk); while (!s_acc);
		items_sent++;
		if (cmd == CMD_CLEAR) clears_sent++;
	endtask

	task automatic add_sample(logic [15:0] x);
		send_item(CMD_ADD, x);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 31) - 16);
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			3: return 16'(16'h8000 + $urandom_range(0, 7));
			4: return 16'(16'h7FFF - $urandom_range(0, 7));
			default: return 16'($urandom_range(0, 4095) - 2048);
		endcase
	endfunction

	initial begin
		int run_len;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty statistics, single sample, extremes, clear with junk sample
		send_item(CMD_CLEAR, 16'h0000);
		add_sample(16'h7FFF);
		add_sample(16'h8000);
		add_sample(16'h0000);
		add_sample(16'hFFFF);
		add_sample(16'h0001);
		send_item(CMD_CLEAR, 16'hFFFF);
		add_sample(16'h8000);
		send_item(CMD_CLEAR, 16'hA5A5);
		add_sample(16'hFFFF);
		add_sample(16'hFFFF);
		send_item(CMD_CLEAR, 16'h5A5A);
		for (int i = 0; i < 10; i++)
			add_sample(i[0] ? 16'h8000 : 16'h7FFF);
		send_item(CMD_CLEAR, 16'h0000);

		// sender keeps offering while the receiver is held off
		hold_cycles = 1500;
		for (int i = 0; i < 12; i++)
			add_sample(rand_sample());

		no_gaps = 1;
		for (int i = 0; i < 40; i++)
			add_sample(rand_sample());
		no_gaps = 0;

		while (items_sent < 930) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(CMD_CLEAR, 16'($urandom_range(0, 65535)));
				run_len = $urandom_range(0, 3);
			end else begin
				run_len = $urandom_range(5, 80);
			end
			for (int i = 0; i < run_len; i++)
				add_sample(rand_sample());
			no_gaps = ($urandom_range(0, 7) == 0);
		end
		s_tvalid <= 1'b0;
		no_gaps = 0;

		wait (pending == 0);
		repeat (400) @(negedge clk);

		$display("Sent %0d items (%0d clears), checked %0d results, peak count %0d.",
			items_sent, clears_sent, results_seen, peak_count);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#6000000;
		$display("Timeout waiting for results");
		$display("DONE: errors detected");
		$finish;
	end

endmodule
